FILE: hw/rtl/mwem_pkg.sv
// ----------------------------------------------------------------------------
// mwem_pkg
// types, codes and defaults shared by the microwire eeprom master
// ----------------------------------------------------------------------------
package mwem_pkg;

    // defaults for the top level parameters
    localparam int DUMMY_CLOCKS_DEF     = 1;
    localparam int START_BITS_DEF       = 1;
    localparam int MAX_ADDRESS_BITS_DEF = 16;

    localparam int OPCODE_BITS = 2;
    localparam int CNT_W       = 5;

    // operation codes
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_WR_EN   = 3'd2;
    localparam logic [2:0] OP_WR_DIS  = 3'd3;
    localparam logic [2:0] OP_POLL    = 3'd4;

    // opcodes sent on the wire
    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_EXT   = 2'b00;

    // request types
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // configuration register indexes
    localparam logic CFG_ADDRESS_BITS = 1'b0;
    localparam logic CFG_WORD_16BIT   = 1'b1;

    localparam logic [4:0] CFG_ADDRESS_BITS_RST = 5'd7;
    localparam logic       CFG_WORD_16BIT_RST   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_DUMMY   = 3'd1,
        ST_START   = 3'd2,
        ST_OPCODE  = 3'd3,
        ST_ADDRESS = 3'd4,
        ST_DATA    = 3'd5,
        ST_TRAIL   = 3'd6,
        ST_POLL    = 3'd7
    } t_mw_stage;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  operation;
        logic [15:0] start_address;
        logic [7:0]  word_count;
        logic        select_line;
        logic        miso;
        logic [15:0] write_word;
    } t_mw_in;

    typedef struct packed {
        logic        sck;
        logic        mosi;
        logic [1:0]  cs_lines;
        logic [15:0] read_word;
        logic        read_valid;
        logic        word_taken;
        logic        done_res;
        logic        busy_res;
    } t_mw_out;

    typedef struct packed {
        t_mw_stage        stage;
        logic             clock_high;
        logic [CNT_W-1:0] bits_left;
        logic [7:0]       words_left;
        logic [15:0]      data_shift;
        logic [15:0]      address_reg;
        logic [2:0]       op_reg;
        logic             select_reg;
        logic             sck;
        logic             mosi;
        logic [1:0]       cs;
    } t_mw_state;

endpackage

FILE: hw/rtl/mwem_step.sv
// ----------------------------------------------------------------------------
// mwem_step
// next state and result for one start or tick item of the microwire sequence
// ----------------------------------------------------------------------------
module mwem_step #(
    parameter int DUMMY_CLOCKS     = mwem_pkg::DUMMY_CLOCKS_DEF,
    parameter int START_BITS       = mwem_pkg::START_BITS_DEF,
    parameter int MAX_ADDRESS_BITS = mwem_pkg::MAX_ADDRESS_BITS_DEF
) (
    input  mwem_pkg::t_mw_state i_state,
    input  mwem_pkg::t_mw_in    i_item,
    input  logic [4:0]          i_address_bits,
    input  logic                i_word_16bit,
    output mwem_pkg::t_mw_state o_state,
    output mwem_pkg::t_mw_out   o_result
);

    localparam logic [mwem_pkg::CNT_W-1:0] DummyCnt = mwem_pkg::CNT_W'(DUMMY_CLOCKS);
    localparam logic [mwem_pkg::CNT_W-1:0] StartCnt = mwem_pkg::CNT_W'(START_BITS);
    localparam logic [mwem_pkg::CNT_W-1:0] OpcCnt   = mwem_pkg::CNT_W'(mwem_pkg::OPCODE_BITS);
    localparam logic [4:0]                 MaxAw    = 5'(MAX_ADDRESS_BITS);

    mwem_pkg::t_mw_state           s;
    logic [mwem_pkg::CNT_W-1:0]    word_len;
    logic [15:0]                   word_mask;
    logic [4:0]                    aw;
    logic [mwem_pkg::CNT_W-1:0]    idx;
    logic [1:0]                    code;
    logic [15:0]                   rword;
    logic                          rvalid;
    logic                          taken;
    logic                          done;

    always_comb begin
        word_len  = i_word_16bit ? mwem_pkg::CNT_W'(16) : mwem_pkg::CNT_W'(8);
        word_mask = i_word_16bit ? 16'hffff : 16'h00ff;
        if (i_address_bits == 5'd0) begin
            aw = 5'd1;
        end else if (i_address_bits > MaxAw) begin
            aw = MaxAw;
        end else begin
            aw = i_address_bits;
        end
        case (i_state.op_reg)
            mwem_pkg::OP_READ:  code = mwem_pkg::OPC_READ;
            mwem_pkg::OP_WRITE: code = mwem_pkg::OPC_WRITE;
            default:            code = mwem_pkg::OPC_EXT;
        endcase
        idx    = i_state.bits_left - mwem_pkg::CNT_W'(1);
        s      = i_state;
        rword  = '0;
        rvalid = 1'b0;
        taken  = 1'b0;
        done   = 1'b0;

        if (i_item.req_type == mwem_pkg::REQ_START) begin
            // unknown operations leave everything as it was
            if (i_item.operation <= mwem_pkg::OP_POLL) begin
                s.op_reg      = i_item.operation;
                s.address_reg = i_item.start_address;
                s.words_left  = (i_item.word_count == 8'd0) ? 8'd1 : i_item.word_count;
                s.select_reg  = i_item.select_line;
                s.data_shift  = '0;
                s.clock_high  = 1'b0;
                s.sck         = 1'b0;
                s.cs          = 2'b00;
                if (i_item.operation == mwem_pkg::OP_POLL) begin
                    s.stage                = mwem_pkg::ST_POLL;
                    s.bits_left            = '0;
                    s.cs[i_item.select_line] = 1'b1;
                end else if (DUMMY_CLOCKS > 0) begin
                    s.stage     = mwem_pkg::ST_DUMMY;
                    s.bits_left = DummyCnt;
                end else begin
                    s.stage     = mwem_pkg::ST_START;
                    s.bits_left = StartCnt;
                end
            end
        end else if (i_state.stage == mwem_pkg::ST_POLL) begin
            if (i_item.miso) begin
                s.cs[i_state.select_reg] = 1'b0;
                s.stage                  = mwem_pkg::ST_IDLE;
                done                     = 1'b1;
            end
        end else if (i_state.stage != mwem_pkg::ST_IDLE) begin
            if (!i_state.clock_high) begin
                // drive mosi ahead of the rising edge
                case (i_state.stage)
                    mwem_pkg::ST_START: begin
                        s.cs[i_state.select_reg] = 1'b1;
                        s.mosi                   = 1'b1;
                    end
                    mwem_pkg::ST_OPCODE: begin
                        if (idx == mwem_pkg::CNT_W'(0)) begin
                            s.mosi = code[0];
                        end else if (idx == mwem_pkg::CNT_W'(1)) begin
                            s.mosi = code[1];
                        end else begin
                            s.mosi = 1'b0;
                        end
                    end
                    mwem_pkg::ST_ADDRESS: begin
                        if (i_state.op_reg == mwem_pkg::OP_WR_EN) begin
                            s.mosi = 1'b1;
                        end else if (i_state.op_reg == mwem_pkg::OP_WR_DIS) begin
                            s.mosi = 1'b0;
                        end else begin
                            s.mosi = i_state.address_reg[idx[3:0]];
                        end
                    end
                    mwem_pkg::ST_DATA: begin
                        if (i_state.op_reg == mwem_pkg::OP_WRITE) begin
                            if (i_state.bits_left == word_len) begin
                                s.data_shift = i_item.write_word & word_mask;
                                taken        = 1'b1;
                            end
                            s.mosi = s.data_shift[idx[3:0]];
                        end
                    end
                    mwem_pkg::ST_TRAIL: begin
                        s.cs[i_state.select_reg] = 1'b0;
                    end
                    default: begin
                    end
                endcase
                s.clock_high = 1'b1;
                s.sck        = 1'b1;
            end else begin
                // falling edge: sample miso and step the sequence
                s.bits_left = idx;
                case (i_state.stage)
                    mwem_pkg::ST_DUMMY: begin
                        if (idx == '0) begin
                            s.stage     = mwem_pkg::ST_START;
                            s.bits_left = StartCnt;
                        end
                    end
                    mwem_pkg::ST_START: begin
                        if (idx == '0) begin
                            s.stage     = mwem_pkg::ST_OPCODE;
                            s.bits_left = OpcCnt;
                        end
                    end
                    mwem_pkg::ST_OPCODE: begin
                        if (idx == '0) begin
                            s.stage     = mwem_pkg::ST_ADDRESS;
                            s.bits_left = aw;
                        end
                    end
                    mwem_pkg::ST_ADDRESS: begin
                        if (idx == '0) begin
                            if (i_state.op_reg <= mwem_pkg::OP_WRITE) begin
                                s.stage      = mwem_pkg::ST_DATA;
                                s.bits_left  = word_len;
                                s.data_shift = '0;
                            end else begin
                                s.stage     = mwem_pkg::ST_TRAIL;
                                s.bits_left = mwem_pkg::CNT_W'(1);
                            end
                        end
                    end
                    mwem_pkg::ST_DATA: begin
                        if (i_state.op_reg == mwem_pkg::OP_READ) begin
                            s.data_shift = {i_state.data_shift[14:0], i_item.miso};
                        end
                        if (idx == '0) begin
                            if (i_state.op_reg == mwem_pkg::OP_READ) begin
                                rword  = s.data_shift & word_mask;
                                rvalid = 1'b1;
                            end
                            s.words_left = i_state.words_left - 8'd1;
                            if (s.words_left != 8'd0) begin
                                s.bits_left  = word_len;
                                s.data_shift = '0;
                            end else begin
                                s.cs[i_state.select_reg] = 1'b0;
                                s.stage                  = mwem_pkg::ST_IDLE;
                                done                     = 1'b1;
                            end
                        end
                    end
                    mwem_pkg::ST_TRAIL: begin
                        s.stage     = mwem_pkg::ST_IDLE;
                        s.bits_left = '0;
                        done        = 1'b1;
                    end
                    default: begin
                    end
                endcase
                s.clock_high = 1'b0;
                s.sck        = 1'b0;
            end
        end
    end

    assign o_state             = s;
    assign o_result.sck        = s.sck;
    assign o_result.mosi       = s.mosi;
    assign o_result.cs_lines   = s.cs;
    assign o_result.read_word  = rword;
    assign o_result.read_valid = rvalid;
    assign o_result.word_taken = taken;
    assign o_result.done_res   = done;
    assign o_result.busy_res   = (s.stage != mwem_pkg::ST_IDLE);

endmodule

FILE: hw/rtl/microwire_eeprom_master_top.sv
// ----------------------------------------------------------------------------
// microwire_eeprom_master_top
// microwire serial eeprom master stepped one sck half-period per tick item
// ----------------------------------------------------------------------------
// Each accepted item (a start or a tick) produces exactly one result, which
// appears in the result register in the cycle after the transfer. The block
// takes one item per clock while its results are taken: the sequencer state
// and the result register are updated together from one combinational step,
// and o_in_ready is high whenever the result register is empty or being taken
// in the same cycle. Configuration writes are always accepted and should only
// be issued while no operation is running and no result is pending.
module microwire_eeprom_master_top #(
    parameter int DUMMY_CLOCKS     = mwem_pkg::DUMMY_CLOCKS_DEF,
    parameter int START_BITS       = mwem_pkg::START_BITS_DEF,
    parameter int MAX_ADDRESS_BITS = mwem_pkg::MAX_ADDRESS_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mwem_pkg::t_mw_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mwem_pkg::t_mw_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [4:0]        i_cfg_data
);

    mwem_pkg::t_mw_state r_state;
    mwem_pkg::t_mw_state n_state;
    mwem_pkg::t_mw_out   r_out;
    mwem_pkg::t_mw_out   n_out;
    logic                r_out_valid;
    logic [4:0]          r_address_bits;
    logic                r_word_16bit;
    logic                in_xfer;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;

    mwem_step #(
        .DUMMY_CLOCKS     (DUMMY_CLOCKS),
        .START_BITS       (START_BITS),
        .MAX_ADDRESS_BITS (MAX_ADDRESS_BITS)
    ) u_step (
        .i_state        (r_state),
        .i_item         (i_in_data),
        .i_address_bits (r_address_bits),
        .i_word_16bit   (r_word_16bit),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_bits <= mwem_pkg::CFG_ADDRESS_BITS_RST;
            r_word_16bit   <= mwem_pkg::CFG_WORD_16BIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mwem_pkg::CFG_ADDRESS_BITS: r_address_bits <= i_cfg_data;
                mwem_pkg::CFG_WORD_16BIT:   r_word_16bit   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{stage: mwem_pkg::ST_IDLE, default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // busy flag of a pending result matches the sequencer state
    a_busy_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.busy_res == (r_state.stage != mwem_pkg::ST_IDLE)))
        else $error("busy flag disagrees with sequencer state");

    // never two chip selects at once
    a_cs_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_state.cs))
        else $error("both chip-select lines high");

    // sck rests low when idle
    a_idle_sck : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.stage == mwem_pkg::ST_IDLE) |-> !r_state.sck)
        else $error("sck high while idle");

    // a finished operation leaves the block idle
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done reported while still busy");

    // read words and write latches never coincide
    a_rd_wr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_valid) |-> !r_out.word_taken)
        else $error("read word and write latch on one tick");

endmodule
